// File: hw/rtl/tour_two_opt_pass_core_assert.svh
// Assertion macros used by the tour improvement RTL.
`ifndef TOUR_TWO_OPT_PASS_CORE_ASSERT_SVH
`define TOUR_TWO_OPT_PASS_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TOPT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tour_two_opt_pass_core: property failed");
`define TOPT_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tour_two_opt_pass_core: forbidden condition seen");
`else
`define TOPT_ASSERT(name, clk, rst, prop)
`define TOPT_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

// File: hw/rtl/topt_pkg.sv
// Shared types and constants of the tour improvement block.
`default_nettype none

package topt_pkg;

   localparam int MAX_CITIES_DEF = 64;
   localparam int COST_BITS_DEF  = 16;
   localparam int CITY_W         = 6;
   localparam int COST_IN_W      = 16;
   localparam int LEN_W          = 7;
   localparam int MOVES_W        = 13;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;
   localparam logic [LEN_W-1:0] LEN_RESET = 7'd4;

   typedef enum logic [1:0] {
      CMD_WR_COST = 2'd0,
      CMD_WR_TOUR = 2'd1,
      CMD_RUN     = 2'd2,
      CMD_RD_TOUR = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_OPEN_RD,
      ST_OPEN_WR,
      ST_EVAL,
      ST_RB_A,
      ST_RB_B,
      ST_RB_C,
      ST_RB_E,
      ST_RB_F,
      ST_COPY,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      EV_RD_I,
      EV_RD_I1,
      EV_RD_J,
      EV_RD_J1,
      EV_C_II1,
      EV_C_JJ1,
      EV_C_IJ1,
      EV_C_JI1,
      EV_DECIDE
   } eval_type;

   typedef struct packed {
      logic              en;
      logic [CITY_W-1:0] row;
      logic [CITY_W-1:0] col;
   } cost_wr_type;

   typedef struct packed {
      logic [CITY_W-1:0] row;
      logic [CITY_W-1:0] col;
   } cost_rd_type;

endpackage

`default_nettype wire

// File: hw/rtl/topt_cost_store.sv
// Directed cost matrix memory with city id folding and address mapping.
`default_nettype none

module topt_cost_store #(
   parameter int MAX_CITIES = topt_pkg::MAX_CITIES_DEF,
   parameter int COST_BITS  = topt_pkg::COST_BITS_DEF
) (
   input  wire                        clock,
   input  wire topt_pkg::cost_wr_type wr,
   input  wire logic [COST_BITS-1:0]  wr_data,
   input  wire topt_pkg::cost_rd_type rd,
   output logic [COST_BITS-1:0]       rd_data
);

   localparam int CIDX   = $clog2(MAX_CITIES);
   localparam int DEPTH  = MAX_CITIES * MAX_CITIES;
   localparam int CAW    = $clog2(DEPTH);
   localparam int NCODES = 2 ** topt_pkg::CITY_W;

   logic [CIDX-1:0]      city_mod [NCODES];
   logic [COST_BITS-1:0] mem [DEPTH];
   logic [CAW-1:0]       wr_addr;
   logic [CAW-1:0]       rd_addr;
   logic [COST_BITS-1:0] rd_data_ff;

   for (genvar v = 0; v < NCODES; v++) begin : g_mod
      assign city_mod[v] = CIDX'(v % MAX_CITIES);
   end

   assign wr_addr = CAW'(city_mod[wr.row]) * CAW'(MAX_CITIES) + CAW'(city_mod[wr.col]);
   assign rd_addr = CAW'(city_mod[rd.row]) * CAW'(MAX_CITIES) + CAW'(city_mod[rd.col]);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tour_two_opt_pass_core.sv
// Top level of the 2-opt tour improvement block: command decode, pass sequencer, tour memory.
// Holds a directed cost matrix and a closed tour, and runs one 2-opt pass on command. A new
// transaction is taken while the sequencer is idle and the result register is free or being
// emptied. A pass copies the first tour entry to the closing slot, steps through the edge
// pairs, skips adjacent pairs, evaluates the rest from the tour and cost memories, rebuilds
// the tour through a rebuild buffer for every applied move, and reports the moves applied.
// The tour memory, which also holds the rebuild buffer, and the cost memory each have a
// single read port. The pass holds req_ready low until its result is loaded.
`default_nettype none
`include "tour_two_opt_pass_core_assert.svh"

module tour_two_opt_pass_core #(
   parameter int MAX_CITIES = topt_pkg::MAX_CITIES_DEF,
   parameter int COST_BITS  = topt_pkg::COST_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_cmd,
   input  wire logic [topt_pkg::CITY_W-1:0]      req_from_city,
   input  wire logic [topt_pkg::CITY_W-1:0]      req_to_city,
   input  wire logic [topt_pkg::COST_IN_W-1:0]   req_edge_cost,
   input  wire logic [topt_pkg::CITY_W-1:0]      req_tour_position,
   input  wire logic [topt_pkg::CITY_W-1:0]      req_city_id,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [topt_pkg::CITY_W-1:0]           rsp_read_city,
   output logic [topt_pkg::MOVES_W-1:0]          rsp_moves_applied,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire logic [topt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [topt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [topt_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int NW     = $clog2(MAX_CITIES + 1);
   localparam int TDEPTH = 2 * MAX_CITIES + 1;
   localparam int TAW    = $clog2(TDEPTH);
   localparam int SBASE  = MAX_CITIES + 1;
   localparam int SUM_W  = COST_BITS + 1;
   localparam int CW     = topt_pkg::CITY_W;
   localparam int LCW    = (NW > topt_pkg::LEN_W) ? NW : topt_pkg::LEN_W;
   localparam int PCW    = (NW > CW) ? NW : CW;

   topt_pkg::state_type state_ff, state_in;
   topt_pkg::eval_type  step_ff, step_in;
   logic [NW-1:0]       i_ff, i_in, j_ff, j_in, w_ff, w_in, r_ff, r_in, k_ff, k_in;
   logic [NW-1:0]       n_ff, n_in, n_cfg;
   logic [CW-1:0]       ti_ff, ti_in, ti1_ff, ti1_in, tj_ff, tj_in, tj1_ff, tj1_in;
   logic [SUM_W-1:0]    acc_ff, acc_in, alt_sum;
   logic [COST_BITS-1:0] alt_ff, alt_in;
   logic [topt_pkg::MOVES_W-1:0] moves_ff, moves_in;
   logic                rd_ok_ff, rd_ok_in;
   logic [topt_pkg::LEN_W-1:0] tour_length_ff, tour_length_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]       rsp_city_ff, rsp_city_in;
   logic [topt_pkg::MOVES_W-1:0] rsp_moves_ff, rsp_moves_in;
   logic                sc_wv_ff, sc_wv_in;
   logic [NW-1:0]       sc_wa_ff, sc_wa_in;
   logic                tw_v_ff, tw_v_in;
   logic [NW-1:0]       tw_a_ff, tw_a_in;

   logic [CW-1:0]       tmem [TDEPTH];
   logic [CW-1:0]       tmem_rd_ff;
   logic [TAW-1:0]      tmem_ra, tmem_wa;
   logic                tmem_we;
   logic [CW-1:0]       tmem_wd;

   topt_pkg::cost_wr_type cwr;
   topt_pkg::cost_rd_type crd;
   logic [COST_BITS-1:0]  cost_rd_data;

   logic [LCW-1:0]      len_ext;
   logic                pos_ok;
   logic                csr_wr;
   logic                skip;

   function automatic logic [NW-1:0] step_up(input logic [NW-1:0] p, input logic [NW-1:0] m);
      step_up = ((p + NW'(1)) >= m) ? '0 : p + NW'(1);
   endfunction

   function automatic logic [NW-1:0] step_down(input logic [NW-1:0] p,
                                               input logic [NW-1:0] m);
      step_down = (p == '0) ? m - NW'(1) : p - NW'(1);
   endfunction

   function automatic logic [TAW-1:0] sc_addr(input logic [NW-1:0] p);
      sc_addr = TAW'(SBASE) + TAW'(p);
   endfunction

   topt_cost_store #(
      .MAX_CITIES (MAX_CITIES),
      .COST_BITS  (COST_BITS)
   ) u_cost (
      .clock   (clock),
      .wr      (cwr),
      .wr_data (COST_BITS'(req_edge_cost)),
      .rd      (crd),
      .rd_data (cost_rd_data)
   );

   assign len_ext = LCW'(tour_length_ff);
   assign n_cfg   = (len_ext > LCW'(MAX_CITIES)) ? NW'(MAX_CITIES) : NW'(len_ext);
   assign pos_ok  = PCW'(req_tour_position) <= PCW'(MAX_CITIES);
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign req_ready = (state_ff == topt_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign skip      = (j_ff == i_ff) || (j_ff == i_ff + NW'(1)) ||
                      (step_up(j_ff, n_ff) == i_ff);
   assign alt_sum   = SUM_W'(alt_ff) + SUM_W'(cost_rd_data);

   always_comb begin
      tour_length_in = tour_length_ff;
      if (csr_wr && !csr_paddr[2]) begin
         tour_length_in = csr_pwdata[topt_pkg::LEN_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      w_in         = w_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      ti_in        = ti_ff;
      ti1_in       = ti1_ff;
      tj_in        = tj_ff;
      tj1_in       = tj1_ff;
      acc_in       = acc_ff;
      alt_in       = alt_ff;
      moves_in     = moves_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_city_in  = rsp_city_ff;
      rsp_moves_in = rsp_moves_ff;
      sc_wv_in     = 1'b0;
      sc_wa_in     = sc_wa_ff;
      tw_v_in      = 1'b0;
      tw_a_in      = tw_a_ff;
      tmem_ra      = '0;
      cwr          = '0;
      crd          = '0;
      tmem_we      = 1'b0;
      tmem_wa      = '0;
      tmem_wd      = tmem_rd_ff;
      if (sc_wv_ff) begin
         tmem_we = 1'b1;
         tmem_wa = sc_addr(sc_wa_ff);
      end else if (tw_v_ff) begin
         tmem_we = 1'b1;
         tmem_wa = TAW'(tw_a_ff);
      end

      unique case (state_ff)
         topt_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (topt_pkg::cmd_type'(req_cmd))
                  topt_pkg::CMD_WR_COST: begin
                     cwr.en       = 1'b1;
                     cwr.row      = req_from_city;
                     cwr.col      = req_to_city;
                     rsp_valid_in = 1'b1;
                     rsp_city_in  = '0;
                     rsp_moves_in = '0;
                  end
                  topt_pkg::CMD_WR_TOUR: begin
                     tmem_we      = pos_ok;
                     tmem_wa      = TAW'(req_tour_position);
                     tmem_wd      = req_city_id;
                     rsp_valid_in = 1'b1;
                     rsp_city_in  = '0;
                     rsp_moves_in = '0;
                  end
                  topt_pkg::CMD_RUN: begin
                     n_in     = n_cfg;
                     moves_in = '0;
                     state_in = topt_pkg::ST_OPEN_RD;
                  end
                  topt_pkg::CMD_RD_TOUR: begin
                     tmem_ra  = TAW'(req_tour_position);
                     rd_ok_in = pos_ok;
                     state_in = topt_pkg::ST_READ;
                  end
                  default: begin
                     state_in = topt_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         topt_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_city_in  = rd_ok_ff ? tmem_rd_ff : '0;
            rsp_moves_in = '0;
            state_in     = topt_pkg::ST_IDLE;
         end
         topt_pkg::ST_OPEN_RD: begin
            tmem_ra  = '0;
            state_in = topt_pkg::ST_OPEN_WR;
         end
         topt_pkg::ST_OPEN_WR: begin
            tmem_we  = 1'b1;
            tmem_wa  = TAW'(n_ff);
            tmem_wd  = tmem_rd_ff;
            i_in     = '0;
            j_in     = '0;
            step_in  = topt_pkg::EV_RD_I;
            state_in = (n_ff == '0) ? topt_pkg::ST_DONE : topt_pkg::ST_EVAL;
         end
         topt_pkg::ST_EVAL: begin
            unique case (step_ff)
               topt_pkg::EV_RD_I: begin
                  tmem_ra = TAW'(i_ff);
                  if (!skip) begin
                     step_in = topt_pkg::EV_RD_I1;
                  end
               end
               topt_pkg::EV_RD_I1: begin
                  ti_in   = tmem_rd_ff;
                  tmem_ra = TAW'(i_ff) + TAW'(1);
                  step_in = topt_pkg::EV_RD_J;
               end
               topt_pkg::EV_RD_J: begin
                  ti1_in  = tmem_rd_ff;
                  tmem_ra = TAW'(j_ff);
                  step_in = topt_pkg::EV_RD_J1;
               end
               topt_pkg::EV_RD_J1: begin
                  tj_in   = tmem_rd_ff;
                  tmem_ra = TAW'(j_ff) + TAW'(1);
                  step_in = topt_pkg::EV_C_II1;
               end
               topt_pkg::EV_C_II1: begin
                  tj1_in  = tmem_rd_ff;
                  crd.row = ti_ff;
                  crd.col = ti1_ff;
                  step_in = topt_pkg::EV_C_JJ1;
               end
               topt_pkg::EV_C_JJ1: begin
                  acc_in  = SUM_W'(cost_rd_data);
                  crd.row = tj_ff;
                  crd.col = tj1_ff;
                  step_in = topt_pkg::EV_C_IJ1;
               end
               topt_pkg::EV_C_IJ1: begin
                  acc_in  = acc_ff + SUM_W'(cost_rd_data);
                  crd.row = ti_ff;
                  crd.col = tj1_ff;
                  step_in = topt_pkg::EV_C_JI1;
               end
               topt_pkg::EV_C_JI1: begin
                  alt_in  = cost_rd_data;
                  crd.row = tj_ff;
                  crd.col = ti1_ff;
                  step_in = topt_pkg::EV_DECIDE;
               end
               topt_pkg::EV_DECIDE: begin
                  step_in = topt_pkg::EV_RD_I;
                  if (alt_sum <= acc_ff) begin
                     state_in = topt_pkg::ST_RB_A;
                  end
               end
               default: begin
                  step_in = topt_pkg::EV_RD_I;
               end
            endcase
            if ((step_ff == topt_pkg::EV_RD_I && skip) ||
                (step_ff == topt_pkg::EV_DECIDE && !(alt_sum <= acc_ff))) begin
               if (j_ff + NW'(1) < n_ff) begin
                  j_in = j_ff + NW'(1);
               end else begin
                  j_in = '0;
                  i_in = i_ff + NW'(1);
                  if (i_ff + NW'(1) >= n_ff) begin
                     state_in = topt_pkg::ST_DONE;
                  end
               end
            end
         end
         topt_pkg::ST_RB_A: begin
            tmem_ra  = TAW'(i_ff);
            sc_wv_in = 1'b1;
            sc_wa_in = i_ff;
            w_in     = step_up(i_ff, n_ff);
            state_in = topt_pkg::ST_RB_B;
         end
         topt_pkg::ST_RB_B: begin
            tmem_ra  = TAW'(j_ff);
            sc_wv_in = 1'b1;
            sc_wa_in = w_ff;
            w_in     = step_up(w_ff, n_ff);
            r_in     = step_down(j_ff, n_ff);
            state_in = topt_pkg::ST_RB_C;
         end
         topt_pkg::ST_RB_C: begin
            tmem_ra  = TAW'(r_ff);
            sc_wv_in = 1'b1;
            sc_wa_in = w_ff;
            w_in     = step_up(w_ff, n_ff);
            if (r_ff != step_up(i_ff, n_ff)) begin
               r_in = step_down(r_ff, n_ff);
            end else begin
               r_in     = step_up(j_ff, n_ff);
               state_in = topt_pkg::ST_RB_E;
            end
         end
         topt_pkg::ST_RB_E: begin
            tmem_ra  = TAW'(r_ff);
            sc_wv_in = 1'b1;
            sc_wa_in = w_ff;
            w_in     = step_up(w_ff, n_ff);
            r_in     = step_up(r_ff, n_ff);
            state_in = topt_pkg::ST_RB_F;
         end
         topt_pkg::ST_RB_F: begin
            if (r_ff != i_ff) begin
               tmem_ra  = TAW'(r_ff);
               sc_wv_in = 1'b1;
               sc_wa_in = w_ff;
               w_in     = step_up(w_ff, n_ff);
               r_in     = step_up(r_ff, n_ff);
            end else begin
               k_in     = '0;
               state_in = topt_pkg::ST_COPY;
            end
         end
         topt_pkg::ST_COPY: begin
            tmem_ra = sc_addr((k_ff == n_ff) ? '0 : k_ff);
            tw_v_in = 1'b1;
            tw_a_in = k_ff;
            if (k_ff == n_ff) begin
               state_in = topt_pkg::ST_NEXT;
            end else begin
               k_in = k_ff + NW'(1);
            end
         end
         topt_pkg::ST_NEXT: begin
            moves_in = moves_ff + topt_pkg::MOVES_W'(1);
            state_in = topt_pkg::ST_EVAL;
            if (j_ff + NW'(1) < n_ff) begin
               j_in = j_ff + NW'(1);
            end else begin
               j_in = '0;
               i_in = i_ff + NW'(1);
               if (i_ff + NW'(1) >= n_ff) begin
                  state_in = topt_pkg::ST_DONE;
               end
            end
         end
         topt_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_city_in  = '0;
            rsp_moves_in = moves_ff;
            state_in     = topt_pkg::ST_IDLE;
         end
         default: begin
            state_in = topt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= topt_pkg::ST_IDLE;
         step_ff        <= topt_pkg::EV_RD_I;
         rsp_valid_ff   <= 1'b0;
         sc_wv_ff       <= 1'b0;
         tw_v_ff        <= 1'b0;
         tour_length_ff <= topt_pkg::LEN_RESET;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
         sc_wv_ff       <= sc_wv_in;
         tw_v_ff        <= tw_v_in;
         tour_length_ff <= tour_length_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      w_ff         <= w_in;
      r_ff         <= r_in;
      k_ff         <= k_in;
      n_ff         <= n_in;
      ti_ff        <= ti_in;
      ti1_ff       <= ti1_in;
      tj_ff        <= tj_in;
      tj1_ff       <= tj1_in;
      acc_ff       <= acc_in;
      alt_ff       <= alt_in;
      moves_ff     <= moves_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_city_ff  <= rsp_city_in;
      rsp_moves_ff <= rsp_moves_in;
      sc_wa_ff     <= sc_wa_in;
      tw_a_ff      <= tw_a_in;
   end

   always_ff @(posedge clock) begin
      if (tmem_we) begin
         tmem[tmem_wa] <= tmem_wd;
      end
   end

   always_ff @(posedge clock) begin
      tmem_rd_ff <= tmem[tmem_ra];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_city     = rsp_city_ff;
   assign rsp_moves_applied = rsp_moves_ff;
   assign csr_pready        = 1'b1;
   assign csr_prdata        = csr_paddr[2] ? '0 : topt_pkg::CSR_DATA_W'(tour_length_ff);

   `TOPT_ASSERT(a_done_loads_rsp, clock, reset, state_ff == topt_pkg::ST_DONE |=> rsp_valid_ff)
   `TOPT_ASSERT(a_eval_in_range, clock, reset, state_ff == topt_pkg::ST_EVAL |-> (i_ff < n_ff) && (j_ff < n_ff))
   `TOPT_ASSERT_NEVER(a_wb_clash, clock, reset, sc_wv_ff && tw_v_ff)

endmodule

`default_nettype wire
